// ===== sv/tle_pkg.sv =====
// Shared types and constants for the terminal line editor.
`timescale 1ns / 1ps

package tle_pkg;

   localparam int LINE_CAPACITY = 40;
   localparam int LEN_W  = $clog2(LINE_CAPACITY + 1);
   localparam int ADDR_W = (LINE_CAPACITY > 1) ? $clog2(LINE_CAPACITY) : 1;

   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   localparam logic [1:0] REG_ERASE = 2'd0;
   localparam logic [1:0] REG_KILL  = 2'd1;
   localparam logic [1:0] REG_WORD  = 2'd2;
   localparam logic [1:0] REG_END   = 2'd3;

   localparam logic [7:0] ERASE_RESET = 8'd127;
   localparam logic [7:0] KILL_RESET  = 8'd21;
   localparam logic [7:0] WORD_RESET  = 8'd23;
   localparam logic [7:0] END_RESET   = 8'd4;

   localparam logic [7:0] CHAR_SPACE  = 8'd32;
   localparam logic [7:0] CHAR_DEL    = 8'd127;

   typedef enum logic [1:0] {
      KIND_ECHO    = 2'd0,
      KIND_ERASE   = 2'd1,
      KIND_NEWLINE = 2'd2,
      KIND_BELL    = 2'd3
   } tle_kind_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_KILL,
      ST_WORD_SP,
      ST_WORD_CH,
      ST_NL1,
      ST_REPLAY,
      ST_NL2,
      ST_STORE,
      ST_FLUSH
   } tle_state_type;

   typedef struct packed {
      logic [7:0] erase_code;
      logic [7:0] kill_code;
      logic [7:0] word_erase_code;
      logic [7:0] end_code;
   } tle_codes_type;

   typedef struct packed {
      logic         load;
      logic         emit;
      logic         flush;
      tle_kind_type kind;
      logic         src_mem;
      logic         sess_end;
      logic         dec_len;
      logic         clr_len;
      logic         store;
      logic         set_fin;
      logic         idx_clr;
      logic         idx_inc;
      logic         rd_idx;
   } tle_cmd_type;

   typedef struct packed {
      logic ctrl;
      logic hit_end;
      logic hit_erase;
      logic hit_kill;
      logic hit_word;
      logic len_zero;
      logic len_full;
      logic top_space;
      logic idx_last;
      logic finished;
      logic pend_valid;
      logic out_free;
   } tle_stat_type;

endpackage

// ===== sv/tle_csr.sv =====
// Configuration register file with APB-style access.
`timescale 1ns / 1ps

module tle_csr (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [tle_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [tle_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [tle_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                           csr_pready,
   output tle_pkg::tle_codes_type         codes
);
   import tle_pkg::*;

   tle_codes_type codes_ff, codes_in;
   logic [1:0]    reg_idx;
   logic          wr_en;
   logic [7:0]    rd_val;

   assign reg_idx    = csr_paddr[3:2];
   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      codes_in = codes_ff;
      if (wr_en) begin
         case (reg_idx)
            REG_ERASE: codes_in.erase_code      = csr_pwdata[7:0];
            REG_KILL:  codes_in.kill_code       = csr_pwdata[7:0];
            REG_WORD:  codes_in.word_erase_code = csr_pwdata[7:0];
            REG_END:   codes_in.end_code        = csr_pwdata[7:0];
            default:   codes_in = codes_ff;
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         REG_ERASE: rd_val = codes_ff.erase_code;
         REG_KILL:  rd_val = codes_ff.kill_code;
         REG_WORD:  rd_val = codes_ff.word_erase_code;
         REG_END:   rd_val = codes_ff.end_code;
         default:   rd_val = 8'd0;
      endcase
   end

   assign csr_prdata = {{(CSR_DATA_W - 8){1'b0}}, rd_val};
   assign codes      = codes_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         codes_ff.erase_code      <= ERASE_RESET;
         codes_ff.kill_code       <= KILL_RESET;
         codes_ff.word_erase_code <= WORD_RESET;
         codes_ff.end_code        <= END_RESET;
      end else begin
         codes_ff <= codes_in;
      end
   end

endmodule

// ===== sv/tle_ctrl.sv =====
// Controller state machine: sequences edits, replay and result hand-off.
`timescale 1ns / 1ps

module tle_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  tle_pkg::tle_stat_type stat,
   output tle_pkg::tle_cmd_type  cmd
);
   import tle_pkg::*;

   tle_state_type state_ff, state_in;
   logic          slot_ok;

   // a new result may enter the holding slot if it is empty or can drain
   assign slot_ok   = !stat.pend_valid || stat.out_free;
   assign req_stall = (state_ff != ST_IDLE);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid && !stat.finished) state_in = ST_DISPATCH;
         end
         ST_DISPATCH: begin
            if (stat.ctrl) begin
               if (stat.hit_end || stat.hit_erase) begin
                  if (slot_ok) state_in = ST_FLUSH;
               end else if (stat.hit_kill) begin
                  state_in = ST_KILL;
               end else if (stat.hit_word) begin
                  state_in = ST_WORD_SP;
               end else if (slot_ok) begin
                  state_in = ST_FLUSH;
               end
            end else if (stat.len_full) begin
               state_in = ST_NL1;
            end else begin
               state_in = ST_STORE;
            end
         end
         ST_KILL: begin
            if (stat.len_zero) state_in = ST_FLUSH;
         end
         ST_WORD_SP: begin
            if (stat.len_zero) state_in = ST_FLUSH;
            else if (!stat.top_space) state_in = ST_WORD_CH;
         end
         ST_WORD_CH: begin
            if (stat.len_zero || stat.top_space) state_in = ST_FLUSH;
         end
         ST_NL1: begin
            if (slot_ok) state_in = ST_REPLAY;
         end
         ST_REPLAY: begin
            if (slot_ok && stat.idx_last) state_in = ST_NL2;
         end
         ST_NL2: begin
            if (slot_ok) state_in = ST_STORE;
         end
         ST_STORE: begin
            if (slot_ok) state_in = ST_FLUSH;
         end
         ST_FLUSH: begin
            if (!stat.pend_valid || stat.out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd      = '0;
      cmd.kind = KIND_ECHO;
      case (state_ff)
         ST_IDLE: begin
            cmd.load = req_valid;
         end
         ST_DISPATCH: begin
            if (stat.ctrl) begin
               if (stat.hit_end) begin
                  if (stat.len_zero && slot_ok) begin
                     cmd.emit     = 1'b1;
                     cmd.kind     = KIND_NEWLINE;
                     cmd.sess_end = 1'b1;
                     cmd.set_fin  = 1'b1;
                  end
               end else if (stat.hit_erase) begin
                  if (!stat.len_zero && slot_ok) begin
                     cmd.emit    = 1'b1;
                     cmd.kind    = KIND_ERASE;
                     cmd.dec_len = 1'b1;
                  end
               end else if (!stat.hit_kill && !stat.hit_word && slot_ok) begin
                  cmd.emit = 1'b1;
                  cmd.kind = KIND_BELL;
               end
            end
         end
         ST_KILL, ST_WORD_CH: begin
            if (!stat.len_zero && !(state_ff == ST_WORD_CH && stat.top_space) && slot_ok) begin
               cmd.emit    = 1'b1;
               cmd.kind    = KIND_ERASE;
               cmd.dec_len = 1'b1;
            end
         end
         ST_WORD_SP: begin
            if (!stat.len_zero && stat.top_space && slot_ok) begin
               cmd.emit    = 1'b1;
               cmd.kind    = KIND_ERASE;
               cmd.dec_len = 1'b1;
            end
         end
         ST_NL1: begin
            cmd.rd_idx = 1'b1;
            if (slot_ok) begin
               cmd.emit    = 1'b1;
               cmd.kind    = KIND_NEWLINE;
               cmd.idx_clr = 1'b1;
            end
         end
         ST_REPLAY: begin
            cmd.rd_idx = 1'b1;
            if (slot_ok) begin
               cmd.emit    = 1'b1;
               cmd.kind    = KIND_ECHO;
               cmd.src_mem = 1'b1;
               cmd.idx_inc = 1'b1;
            end
         end
         ST_NL2: begin
            if (slot_ok) begin
               cmd.emit    = 1'b1;
               cmd.kind    = KIND_NEWLINE;
               cmd.clr_len = 1'b1;
            end
         end
         ST_STORE: begin
            if (slot_ok) begin
               cmd.emit  = 1'b1;
               cmd.kind  = KIND_ECHO;
               cmd.store = 1'b1;
            end
         end
         ST_FLUSH: begin
            cmd.flush = stat.pend_valid && stat.out_free;
         end
         default: cmd = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== sv/tle_dp.sv =====
// Datapath: line store, length, replay index, holding slot and output register.
`timescale 1ns / 1ps

module tle_dp (
   input  logic                   clock,
   input  logic                   reset,
   input  logic [7:0]             req_in_byte,
   input  tle_pkg::tle_codes_type codes,
   input  tle_pkg::tle_cmd_type   cmd,
   output tle_pkg::tle_stat_type  stat,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [1:0]             rsp_kind,
   output logic [7:0]             rsp_out_byte,
   output logic                   rsp_session_end,
   output logic                   rsp_last
);
   import tle_pkg::*;

   logic [7:0]        mem [LINE_CAPACITY];
   logic [7:0]        rd_data_ff;
   logic [7:0]        byte_ff;
   logic [LEN_W-1:0]  len_ff, len_in;
   logic [ADDR_W-1:0] idx_ff, idx_in;
   logic              fin_ff, fin_in;

   logic              pend_valid_ff, pend_valid_in;
   tle_kind_type      pend_kind_ff;
   logic [7:0]        pend_byte_ff;
   logic              pend_end_ff;

   logic              rsp_valid_ff, rsp_valid_in;
   tle_kind_type      rsp_kind_ff;
   logic [7:0]        rsp_byte_ff;
   logic              rsp_end_ff;
   logic              rsp_last_ff;

   logic [LEN_W-1:0]  rd_wide;
   logic [ADDR_W-1:0] rd_addr;
   logic [ADDR_W-1:0] wr_addr;
   logic              rd_ok;
   logic              push;
   logic [7:0]        new_byte;

   always_comb begin
      len_in = len_ff;
      if (cmd.clr_len) len_in = '0;
      else if (cmd.dec_len) len_in = len_ff - LEN_W'(1);
      else if (cmd.store) len_in = len_ff + LEN_W'(1);
   end

   always_comb begin
      idx_in = idx_ff;
      if (cmd.idx_clr) idx_in = '0;
      else if (cmd.idx_inc) idx_in = idx_ff + ADDR_W'(1);
   end

   assign fin_in = fin_ff || cmd.set_fin;

   // read ahead: address the entry that the next cycle will look at
   always_comb begin
      if (cmd.rd_idx) begin
         rd_wide = LEN_W'(idx_in);
         rd_ok   = (LEN_W'(idx_in) < LEN_W'(LINE_CAPACITY));
      end else begin
         rd_wide = len_in - LEN_W'(1);
         rd_ok   = (len_in != '0);
      end
   end

   assign rd_addr = rd_wide[ADDR_W-1:0];
   assign wr_addr = len_ff[ADDR_W-1:0];

   always_ff @(posedge clock) begin
      if (cmd.store) mem[wr_addr] <= byte_ff;
      if (rd_ok) begin
         // bypass a write to the same entry
         if (cmd.store && (wr_addr == rd_addr)) rd_data_ff <= byte_ff;
         else rd_data_ff <= mem[rd_addr];
      end
   end

   assign stat.ctrl       = (byte_ff < 8'd32) || (byte_ff == CHAR_DEL);
   assign stat.hit_end    = (byte_ff == codes.end_code);
   assign stat.hit_erase  = (byte_ff == codes.erase_code);
   assign stat.hit_kill   = (byte_ff == codes.kill_code);
   assign stat.hit_word   = (byte_ff == codes.word_erase_code);
   assign stat.len_zero   = (len_ff == '0);
   assign stat.len_full   = (len_ff >= LEN_W'(LINE_CAPACITY));
   assign stat.top_space  = (rd_data_ff == CHAR_SPACE);
   assign stat.idx_last   = (idx_ff == ADDR_W'(LINE_CAPACITY - 1));
   assign stat.finished   = fin_ff;
   assign stat.pend_valid = pend_valid_ff;
   assign stat.out_free   = !rsp_valid_ff || !rsp_stall;

   // the holding slot keeps one result back so the final one can carry last
   assign push     = (cmd.emit && pend_valid_ff) || cmd.flush;
   assign new_byte = (cmd.kind != KIND_ECHO) ? 8'd0 : (cmd.src_mem ? rd_data_ff : byte_ff);

   always_comb begin
      pend_valid_in = pend_valid_ff;
      if (cmd.emit) pend_valid_in = 1'b1;
      else if (cmd.flush) pend_valid_in = 1'b0;
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (push) rsp_valid_in = 1'b1;
      else if (!rsp_stall) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (cmd.load) byte_ff <= req_in_byte;
      if (cmd.emit) begin
         pend_kind_ff <= cmd.kind;
         pend_byte_ff <= new_byte;
         pend_end_ff  <= cmd.sess_end;
      end
      if (push) begin
         rsp_kind_ff <= pend_kind_ff;
         rsp_byte_ff <= pend_byte_ff;
         rsp_end_ff  <= pend_end_ff;
         rsp_last_ff <= cmd.flush;
      end
      idx_ff <= idx_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff        <= '0;
         fin_ff        <= 1'b0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         len_ff        <= len_in;
         fin_ff        <= fin_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_kind        = rsp_kind_ff;
   assign rsp_out_byte    = rsp_byte_ff;
   assign rsp_session_end = rsp_end_ff;
   assign rsp_last        = rsp_last_ff;

   a_len_bound: assert property (@(posedge clock) disable iff (reset)
      len_ff <= LEN_W'(LINE_CAPACITY))
      else $error("line length beyond capacity");

   a_fin_sticky: assert property (@(posedge clock) disable iff (reset)
      fin_ff |=> fin_ff)
      else $error("finished flag cleared");

   a_end_shape: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_end_ff) |-> (rsp_kind_ff == KIND_NEWLINE) && rsp_last_ff)
      else $error("session end not on a final newline");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      cmd.dec_len |-> (len_ff != '0))
      else $error("erase on empty line");

   a_slot_overrun: assert property (@(posedge clock) disable iff (reset)
      (cmd.emit && pend_valid_ff) |-> (!rsp_valid_ff || !rsp_stall))
      else $error("held result overwritten");

endmodule

// ===== sv/terminal_line_editor_top.sv =====
// Top level of the terminal line editor.
//
//   channel  direction  handshake              payload
//   req      in         req_valid / req_stall  req_in_byte
//   rsp      out        rsp_valid / rsp_stall  rsp_kind, rsp_out_byte, rsp_session_end, rsp_last
//   csr      in         APB psel/penable       csr_paddr, csr_pwdata -> csr_prdata
//
// One transaction at a time: req_stall is high from the accepting edge until idle again.
// Bell, erase and end emit in the decode cycle; a stored byte is echoed as it is written. Kill
// erases back to the empty line; word erase removes trailing spaces, then the word; a byte on a
// full line emits newline, replays the line store one entry per cycle while the output is free,
// then newline and the byte. Synchronous reset clears length, session flag and handshake state
// and restores the default codes; no store clearing. A result held by rsp_stall holds the sequence.
`timescale 1ns / 1ps

module terminal_line_editor_top (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [7:0]                     req_in_byte,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [1:0]                     rsp_kind,
   output logic [7:0]                     rsp_out_byte,
   output logic                           rsp_session_end,
   output logic                           rsp_last,
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [tle_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [tle_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [tle_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                           csr_pready
);
   import tle_pkg::*;

   tle_codes_type codes;
   tle_cmd_type   cmd;
   tle_stat_type  stat;

   tle_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .codes       (codes)
   );

   tle_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   tle_dp u_dp (
      .clock           (clock),
      .reset           (reset),
      .req_in_byte     (req_in_byte),
      .codes           (codes),
      .cmd             (cmd),
      .stat            (stat),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_kind        (rsp_kind),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_session_end (rsp_session_end),
      .rsp_last        (rsp_last)
   );

endmodule
